@@ hdl/apbq_pkg.sv @@
`timescale 1ns / 1ps

package apbq_pkg;

    // Divider operand widths: theta << 25 needs 49 bits, Q needs 24.
    localparam int DIVD_W = 49;
    localparam int DIVS_W = 24;

    // Shared multiplier operand width (magnitudes).
    localparam int MUL_W = 33;

    localparam logic [23:0] THETA_MIN = 24'd419;
    localparam logic [23:0] THETA_MAX = 24'd8388608;

    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
    localparam logic [48:0] LN2_Q32     = 49'd2977044472;
    localparam logic [48:0] EXP_ZERO_A  = 49'd98242467576;   // 33 * ln2 in Q.32

    localparam logic [3:0] HORNER_TERMS = 4'd12;

    localparam logic CFG_RAD_PER_UNIT = 1'b0;
    localparam logic CFG_BLOCK_LENGTH = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TH_MUL,
        S_TH_CLAMP,
        S_A_START,
        S_A_WAIT,
        S_RED,
        S_HMUL,
        S_H_START,
        S_H_WAIT,
        S_EXP,
        S_SQ,
        S_SQ2,
        S_COS,
        S_CMUL,
        S_CFIN,
        S_F0,
        S_F1,
        S_F2,
        S_F3,
        S_F4,
        S_Y
    } t_state;

endpackage

@@ hdl/allpass_biquad_swept_unit.sv @@
`timescale 1ns / 1ps

// Swept second-order all-pass filter (direct form I), one sample per word.
// Input channel: i_in_valid / o_in_stall carries sample, frequency and Q.
// Output channel: o_out_valid / i_out_stall carries the filtered sample.
// Config port: i_cfg_we writes rad_per_unit (index 0) or block_length
// (index 1); write only while the unit is idle.
// A plain sample runs through four passes of the shared 33x33 multiplier,
// the last accumulate and the rounding step from accept to output; the
// next word can be accepted in the cycle after the output is written. At
// block position 0 and at the block midpoint the coefficients are rebuilt
// first: theta multiply, a 49-step serial divide for theta/(2Q), the ln2
// reduction steps, a 12-term Horner series that runs one multiply and
// one 49-step divide per term, then r2 and the cross term. One word is
// in flight at a time.
// Reset clears the delay line, coefficients and block position and loads
// the register defaults. A stalled output word holds in the output
// register; the next word may be accepted meanwhile and waits in its final
// step until the output register frees up.
module allpass_biquad_swept_unit #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int MAX_BLOCK    = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic [19:0]             i_freq_control,
    input  logic [23:0]             i_q_control,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [SAMPLE_WIDTH-1:0] o_sample_out,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [31:0]             i_cfg_data
);
    import apbq_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int POS_W = $clog2(MAX_BLOCK);
    localparam int LEN_W = POS_W + 1;
    localparam int ACC_W = SW + 29;

    // Config registers
    logic [31:0] r_rpu;
    logic [12:0] r_blen;

    // Sequencer and captured word
    t_state r_state, n_state;
    logic signed [SW-1:0] r_x;
    logic [19:0]          r_freq;
    logic [23:0]          r_q;

    // Filter state
    logic signed [SW-1:0] r_x1, r_x2, r_y1, r_y2;
    logic [23:0]          r_coef_sq;
    logic signed [24:0]   r_coef_cross;
    logic [POS_W-1:0]     r_pos;

    // Coefficient working registers
    logic [23:0]          r_theta;
    logic [48:0]          r_a;
    logic [5:0]           r_n;
    logic [32:0]          r_p;
    logic [3:0]           r_k;
    logic [31:0]          r_e;
    logic signed [26:0]   r_cosa;

    // Shared multiplier
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic                 mul_neg;
    logic [2*MUL_W-1:0]   r_prod;
    logic                 r_prod_neg;

    logic signed [ACC_W-1:0] r_acc;

    logic                 r_out_valid;
    logic [SW-1:0]        r_sample_out;

    // Divider hookup
    logic                 div_start;
    logic [DIVD_W-1:0]    div_dividend;
    logic [DIVS_W-1:0]    div_divisor;
    logic                 div_done;
    logic [DIVD_W-1:0]    div_quo;

    apbq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    logic in_acc, out_free;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Block position bookkeeping: clamp the length, restart a position that
    // fell off a shortened block, flag coefficient updates.
    logic [31:0]      blen_ext, len32;
    logic [LEN_W-1:0] len, pos_eff, pos_inc, pos_next;
    logic             upd;

    always_comb begin
        blen_ext = 32'(r_blen);
        if (blen_ext < 32'd2)
            len32 = 32'd2;
        else if (blen_ext > 32'(MAX_BLOCK))
            len32 = 32'(MAX_BLOCK);
        else
            len32 = blen_ext;
        len      = len32[LEN_W-1:0];
        pos_eff  = ({1'b0, r_pos} >= len) ? '0 : {1'b0, r_pos};
        upd      = (pos_eff == '0) || (pos_eff == (len >> 1));
        pos_inc  = pos_eff + 1'b1;
        pos_next = (pos_inc >= len) ? '0 : pos_inc;
    end

    // Coefficient arithmetic taken from the registered product
    logic [55:0] th_raw;
    logic [23:0] th_clamped;
    logic [26:0] sq_sum;
    logic [25:0] sq_half;
    logic [23:0] sq_sat;
    logic [47:0] half_sum;
    logic [25:0] half;
    logic [32:0] p_shift;
    logic [65:0] rnd_sum;
    logic [25:0] rnd;
    logic        cosa_pos;
    logic [26:0] cosa_mag;
    logic signed [25:0] c_full;
    logic signed [24:0] c_sat;

    always_comb begin
        th_raw = r_prod[65:10];
        if (th_raw > 56'(THETA_MAX))
            th_clamped = THETA_MAX;
        else if (th_raw < 56'(THETA_MIN))
            th_clamped = THETA_MIN;
        else
            th_clamped = th_raw[23:0];

        sq_sum  = {1'b0, r_prod[64:39]} + 27'd1;
        sq_half = sq_sum[26:1];
        sq_sat  = (sq_half > 26'd16777215) ? 24'hFF_FFFF : sq_half[23:0];

        half_sum = r_prod[47:0] + 48'd2097152;
        half     = half_sum[47:22];

        p_shift = r_p >> r_n;

        cosa_pos = !r_cosa[26] && (r_cosa != '0);
        cosa_mag = r_cosa[26] ? 27'(-r_cosa) : 27'(r_cosa);
        rnd_sum  = r_prod + 66'd1073741824;
        rnd      = rnd_sum[56:31];
        if (cosa_pos)
            c_full = -$signed(rnd);
        else
            c_full = $signed(rnd);
        if (c_full > 26'sd16777215)
            c_sat = 25'sd16777215;
        else
            c_sat = c_full[24:0];
    end

    // Filter operand magnitudes and signs
    logic [SW-1:0] x_mag, x1_mag, y1_mag, y2_mag;
    logic [24:0]   c_mag;
    logic          c_neg;

    always_comb begin
        x_mag  = r_x[SW-1]  ? SW'(-r_x)  : SW'(r_x);
        x1_mag = r_x1[SW-1] ? SW'(-r_x1) : SW'(r_x1);
        y1_mag = r_y1[SW-1] ? SW'(-r_y1) : SW'(r_y1);
        y2_mag = r_y2[SW-1] ? SW'(-r_y2) : SW'(r_y2);
        c_neg  = r_coef_cross[24];
        c_mag  = c_neg ? 25'(-r_coef_cross) : 25'(r_coef_cross);
    end

    // Accumulate one term and round the result
    logic [ACC_W-1:0]        term;
    logic signed [ACC_W-1:0] acc_n;
    logic signed [ACC_W-1:0] acc_rnd, y_full, y_max, y_min;
    logic [SW-1:0]           y_sat;

    always_comb begin
        if (r_state == S_F2 || r_state == S_F3)
            term = {r_prod[ACC_W-2:0], 1'b0};
        else
            term = r_prod[ACC_W-1:0];
        acc_n = r_prod_neg ? (r_acc - $signed(term)) : (r_acc + $signed(term));

        acc_rnd = r_acc + ACC_W'(64'd8388608);
        y_full  = acc_rnd >>> 24;
        y_max   = ACC_W'($signed({1'b0, {(SW-1){1'b1}}}));
        y_min   = ~y_max;
        if (y_full > y_max)
            y_sat = y_max[SW-1:0];
        else if (y_full < y_min)
            y_sat = y_min[SW-1:0];
        else
            y_sat = y_full[SW-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (in_acc) n_state = upd ? S_TH_MUL : S_F0;
            S_TH_MUL:   n_state = S_TH_CLAMP;
            S_TH_CLAMP: n_state = S_A_START;
            S_A_START:  n_state = S_A_WAIT;
            S_A_WAIT:   if (div_done) n_state = S_RED;
            S_RED: begin
                if (r_a >= EXP_ZERO_A)
                    n_state = S_SQ;
                else if (r_a < LN2_Q32)
                    n_state = S_HMUL;
            end
            S_HMUL:     n_state = S_H_START;
            S_H_START:  n_state = S_H_WAIT;
            S_H_WAIT:   if (div_done) n_state = (r_k == 4'd1) ? S_EXP : S_HMUL;
            S_EXP:      n_state = S_SQ;
            S_SQ:       n_state = S_SQ2;
            S_SQ2:      n_state = S_COS;
            S_COS:      n_state = S_CMUL;
            S_CMUL:     n_state = S_CFIN;
            S_CFIN:     n_state = S_F0;
            S_F0:       n_state = S_F1;
            S_F1:       n_state = S_F2;
            S_F2:       n_state = S_F3;
            S_F3:       n_state = S_F4;
            S_F4:       n_state = S_Y;
            S_Y:        if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Shared unit operand steering
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        mul_neg      = 1'b0;
        div_start    = 1'b0;
        div_dividend = {r_theta, 25'd0};
        div_divisor  = (r_q == '0) ? 24'd1 : r_q;
        case (r_state)
            S_TH_MUL: begin
                mul_a = {1'b0, r_rpu};
                mul_b = MUL_W'(r_freq);
            end
            S_A_START: div_start = 1'b1;
            S_HMUL: begin
                mul_a = {1'b0, r_a[31:0]};
                mul_b = r_p;
            end
            S_H_START: begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(r_prod[65:32]);
                div_divisor  = DIVS_W'(r_k);
            end
            S_SQ: begin
                mul_a = {1'b0, r_e};
                mul_b = {1'b0, r_e};
            end
            S_SQ2: begin
                mul_a = MUL_W'(r_theta);
                mul_b = MUL_W'(r_theta);
            end
            S_CMUL: begin
                mul_a = MUL_W'(cosa_mag);
                mul_b = {1'b0, r_e};
            end
            S_F0: begin
                mul_a   = MUL_W'(r_coef_sq);
                mul_b   = MUL_W'(x_mag);
                mul_neg = r_x[SW-1];
            end
            S_F1: begin
                mul_a   = MUL_W'(c_mag);
                mul_b   = MUL_W'(x1_mag);
                mul_neg = c_neg ^ r_x1[SW-1];
            end
            S_F2: begin
                mul_a   = MUL_W'(c_mag);
                mul_b   = MUL_W'(y1_mag);
                mul_neg = ~(c_neg ^ r_y1[SW-1]);
            end
            S_F3: begin
                mul_a   = MUL_W'(r_coef_sq);
                mul_b   = MUL_W'(y2_mag);
                mul_neg = ~r_y2[SW-1];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // Multiplier output register
    always_ff @(posedge i_clk) begin
        r_prod     <= mul_a * mul_b;
        r_prod_neg <= mul_neg;
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpu  <= 32'd35137;
            r_blen <= 13'd64;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_RAD_PER_UNIT)
                r_rpu <= i_cfg_data;
            else
                r_blen <= i_cfg_data[12:0];
        end
    end

    // Output valid: raise when a word lands in the output register, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (r_state == S_Y && out_free)
            r_out_valid <= 1'b1;
        else if (!i_out_stall)
            r_out_valid <= 1'b0;
    end

    // Sequencer, filter state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_x1         <= '0;
            r_x2         <= '0;
            r_y1         <= '0;
            r_y2         <= '0;
            r_coef_sq    <= '0;
            r_coef_cross <= '0;
            r_pos        <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_x    <= i_sample_in;
                        r_freq <= i_freq_control;
                        r_q    <= i_q_control;
                        r_pos  <= pos_next[POS_W-1:0];
                    end
                end
                S_TH_CLAMP: r_theta <= th_clamped;
                S_A_WAIT: begin
                    r_a <= div_quo;
                    r_n <= '0;
                end
                S_RED: begin
                    if (r_a >= EXP_ZERO_A) begin
                        r_e <= '0;
                    end else if (r_a >= LN2_Q32) begin
                        r_a <= r_a - LN2_Q32;
                        r_n <= r_n + 1'b1;
                    end else begin
                        r_p <= ONE_Q32;
                        r_k <= HORNER_TERMS;
                    end
                end
                S_H_WAIT: begin
                    if (div_done) begin
                        r_p <= ONE_Q32 - div_quo[32:0];
                        r_k <= r_k - 1'b1;
                    end
                end
                S_EXP:  r_e <= p_shift[32] ? 32'hFFFF_FFFF : p_shift[31:0];
                S_SQ2:  r_coef_sq <= sq_sat;
                S_COS:  r_cosa <= 27'sd8388608 - $signed({1'b0, half});
                S_CFIN: r_coef_cross <= c_sat;
                S_F0:   r_acc <= $signed({{5{r_x2[SW-1]}}, r_x2, 24'd0});
                S_F1, S_F2, S_F3, S_F4: r_acc <= acc_n;
                S_Y: begin
                    if (out_free) begin
                        r_sample_out <= y_sat;
                        r_x2         <= r_x1;
                        r_x1         <= r_x;
                        r_y2         <= r_y1;
                        r_y1         <= $signed(y_sat);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

@@ hdl/apbq_div.sv @@
`timescale 1ns / 1ps

module apbq_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [apbq_pkg::DIVD_W-1:0] i_dividend,
    input  logic [apbq_pkg::DIVS_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [apbq_pkg::DIVD_W-1:0] o_quotient
);
    import apbq_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;
    logic [DIVS_W-1:0] n_rem;

    // One restoring step per cycle, quotient bits shift in behind the dividend.
    always_comb begin
        trial = {r_rem, r_quo[DIVD_W-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
        n_rem = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= CNT_W'(DIVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIVD_W-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
